// ----- rtl/core/weighted_multi_pattern_matcher_defines.svh -----
// ---------------------------------------------------------------------------
// weighted multi pattern matcher assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_MULTI_PATTERN_MATCHER_DEFINES_SVH
`define WEIGHTED_MULTI_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication
`define WMPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wmpm same-cycle check failed");

// next-cycle implication
`define WMPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wmpm next-cycle check failed");

`endif

// ----- rtl/core/wmpm_pkg.sv -----
// ---------------------------------------------------------------------------
// wmpm_pkg
// field widths, request codes and controller/datapath handshake structs
// ---------------------------------------------------------------------------
package wmpm_pkg;

	localparam int REQ_W    = 3;
	localparam int SLOT_W   = 12;
	localparam int SYM_W    = 5;
	localparam int LINK_W   = 12;
	localparam int FIRST_W  = 12;
	localparam int COUNT_W  = 11;
	localparam int PID_W    = 10;
	localparam int WEIGHT_W = 24;
	localparam int TOTAL_W  = 40;
	localparam int IDX_W    = 13;
	localparam int SPAN_W   = FIRST_W + COUNT_W;

	localparam logic [REQ_W-1:0] REQ_GOTO   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INFO   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_OUTPUT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_WEIGHT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CHAR   = 3'd4;

	typedef struct packed {
		logic clr_step;
		logic load_wr;
		logic char_start;
		logic goto_rd;
		logic goto_step;
		logic take_edge;
		logic span_rd;
		logic list_rd;
		logic wt_rd;
		logic acc;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_char;
		logic bad_sym;
		logic edge_hit;
		logic give_up;
		logic list_more;
		logic out_full;
		logic is_end;
	} sts_t;

endpackage

// ----- rtl/core/wmpm_req_if.sv -----
// ---------------------------------------------------------------------------
// wmpm_req_if
// request channel: load writes and text characters
// ---------------------------------------------------------------------------
interface wmpm_req_if;
	logic                              valid;
	logic                              ready;
	logic [wmpm_pkg::REQ_W-1:0]        req_type;
	logic [wmpm_pkg::SLOT_W-1:0]       slot;
	logic [wmpm_pkg::SYM_W-1:0]        symbol;
	logic [wmpm_pkg::LINK_W-1:0]       link;
	logic                              has_edge;
	logic [wmpm_pkg::FIRST_W-1:0]      out_first;
	logic [wmpm_pkg::COUNT_W-1:0]      out_count;
	logic [wmpm_pkg::PID_W-1:0]        pattern_id;
	logic [wmpm_pkg::WEIGHT_W-1:0]     weight;
	logic [wmpm_pkg::PID_W-1:0]        range_first;
	logic [wmpm_pkg::PID_W-1:0]        range_last;
	logic                              strand_end;

	modport source (output valid, req_type, slot, symbol, link, has_edge, out_first,
		out_count, pattern_id, weight, range_first, range_last, strand_end, input ready);
	modport sink (input valid, req_type, slot, symbol, link, has_edge, out_first,
		out_count, pattern_id, weight, range_first, range_last, strand_end, output ready);
endinterface

// ----- rtl/core/wmpm_res_if.sv -----
// ---------------------------------------------------------------------------
// wmpm_res_if
// result channel: strand totals
// ---------------------------------------------------------------------------
interface wmpm_res_if;
	logic                          valid;
	logic                          ready;
	logic [wmpm_pkg::TOTAL_W-1:0]  strand_total;
	logic                          saturated;

	modport source (output valid, strand_total, saturated, input ready);
	modport sink (input valid, strand_total, saturated, output ready);
endinterface

// ----- rtl/core/wmpm_dp.sv -----
// ---------------------------------------------------------------------------
// wmpm_dp
// automaton memories, state walk registers and saturating accumulator
// ---------------------------------------------------------------------------
module wmpm_dp #(
	parameter int STATES      = 4096,
	parameter int ALPHABET    = 26,
	parameter int PATTERNS    = 1024,
	parameter int OUT_ENTRIES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	wmpm_req_if.sink         req,
	wmpm_res_if.source       res,
	input  wmpm_pkg::cmd_t   cmd,
	output wmpm_pkg::sts_t   sts
);
	localparam int GDEPTH = STATES * ALPHABET;
	localparam int SW  = ($clog2(STATES) > 0) ? $clog2(STATES) : 1;
	localparam int GW  = ($clog2(GDEPTH) > 0) ? $clog2(GDEPTH) : 1;
	localparam int LW  = ($clog2(OUT_ENTRIES) > 0) ? $clog2(OUT_ENTRIES) : 1;
	localparam int PW  = ($clog2(PATTERNS) > 0) ? $clog2(PATTERNS) : 1;
	localparam int STW = $clog2(STATES + 1);
	localparam logic [wmpm_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

	logic [SW:0]                    goto_mem [GDEPTH];
	logic [SW-1:0]                  fail_mem [STATES];
	logic [wmpm_pkg::SPAN_W-1:0]    span_mem [STATES];
	logic [wmpm_pkg::PID_W-1:0]     list_mem [OUT_ENTRIES];
	logic [wmpm_pkg::WEIGHT_W-1:0]  wt_mem   [PATTERNS];

	logic [SW:0]                    goto_rd_q;
	logic [SW-1:0]                  fail_rd_q;
	logic [wmpm_pkg::SPAN_W-1:0]    span_rd_q;
	logic [wmpm_pkg::PID_W-1:0]     list_rd_q;
	logic [wmpm_pkg::WEIGHT_W-1:0]  wt_rd_q;

	logic [GW-1:0]                  clr_q;
	logic [wmpm_pkg::SYM_W-1:0]     sym_q;
	logic [wmpm_pkg::PID_W-1:0]     lo_q, hi_q;
	logic                           end_q;
	logic [SW-1:0]                  probe_q, next_q, cur_q;
	logic [STW-1:0]                 steps_q;
	logic [wmpm_pkg::COUNT_W-1:0]   i_q;
	logic                           idx_ok_q, hit_q;
	logic [wmpm_pkg::TOTAL_W-1:0]   total_q, out_total_q;
	logic                           clamp_q, out_sat_q, out_valid_q;

	logic [31:0] slot32, link32, gw_addr32, gr_addr32, idx32, pid32;
	logic [SW-1:0] link_fix;
	logic slot_st_ok;
	logic [wmpm_pkg::FIRST_W-1:0] span_first;
	logic [wmpm_pkg::COUNT_W-1:0] span_count;
	logic [wmpm_pkg::IDX_W-1:0]   idx;
	logic [wmpm_pkg::TOTAL_W:0]   sum;
	logic pid_hit;

	always_comb begin
		slot32     = 32'(req.slot);
		link32     = (32'(req.link) < 32'(STATES)) ? 32'(req.link) : 32'd0;
		link_fix   = link32[SW-1:0];
		slot_st_ok = slot32 < 32'(STATES);
		gw_addr32  = slot32 * 32'(ALPHABET) + 32'(req.symbol);
		gr_addr32  = 32'(probe_q) * 32'(ALPHABET) + 32'(sym_q);
		span_first = span_rd_q[wmpm_pkg::SPAN_W-1 -: wmpm_pkg::FIRST_W];
		span_count = span_rd_q[wmpm_pkg::COUNT_W-1:0];
		idx        = wmpm_pkg::IDX_W'(span_first) + wmpm_pkg::IDX_W'(i_q);
		idx32      = 32'(idx);
		pid32      = 32'(list_rd_q);
		pid_hit    = idx_ok_q && (pid32 < 32'(PATTERNS)) &&
			(list_rd_q >= lo_q) && (list_rd_q <= hi_q);
		sum        = {1'b0, total_q} + (wmpm_pkg::TOTAL_W + 1)'(wt_rd_q);
	end

	// goto table, cleared by the sweep after reset
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			goto_mem[clr_q] <= '0;
		end else if (cmd.load_wr && req.req_type == wmpm_pkg::REQ_GOTO && slot_st_ok &&
				32'(req.symbol) < 32'(ALPHABET)) begin
			goto_mem[gw_addr32[GW-1:0]] <= req.has_edge ? {1'b1, link_fix} : '0;
		end
		if (cmd.goto_rd) begin
			goto_rd_q <= goto_mem[gr_addr32[GW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && req.req_type == wmpm_pkg::REQ_INFO && slot_st_ok) begin
			fail_mem[slot32[SW-1:0]] <= link_fix;
		end
		if (cmd.goto_rd) begin
			fail_rd_q <= fail_mem[probe_q];
		end
	end

	// span store, zero count for every state after the sweep
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			if (32'(clr_q) < 32'(STATES)) begin
				span_mem[clr_q[SW-1:0]] <= '0;
			end
		end else if (cmd.load_wr && req.req_type == wmpm_pkg::REQ_INFO && slot_st_ok) begin
			span_mem[slot32[SW-1:0]] <= {req.out_first, req.out_count};
		end
		if (cmd.span_rd) begin
			span_rd_q <= span_mem[next_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && req.req_type == wmpm_pkg::REQ_OUTPUT &&
				slot32 < 32'(OUT_ENTRIES)) begin
			list_mem[slot32[LW-1:0]] <= req.pattern_id;
		end
		if (cmd.list_rd) begin
			list_rd_q <= list_mem[idx32[LW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && req.req_type == wmpm_pkg::REQ_WEIGHT &&
				slot32 < 32'(PATTERNS)) begin
			wt_mem[slot32[PW-1:0]] <= req.weight;
		end
		if (cmd.wt_rd) begin
			wt_rd_q <= wt_mem[pid32[PW-1:0]];
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		if (cmd.char_start) begin
			sym_q   <= req.symbol;
			lo_q    <= req.range_first;
			hi_q    <= req.range_last;
			end_q   <= req.strand_end;
			probe_q <= cur_q;
			steps_q <= '0;
			next_q  <= '0;
		end
		if (cmd.goto_step) begin
			probe_q <= fail_rd_q;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.take_edge) begin
			next_q <= goto_rd_q[SW] ? goto_rd_q[SW-1:0] : '0;
		end
		if (cmd.span_rd) begin
			i_q <= '0;
		end
		if (cmd.list_rd) begin
			idx_ok_q <= idx32 < 32'(OUT_ENTRIES);
			i_q      <= i_q + 1'b1;
		end
		if (cmd.wt_rd) begin
			hit_q <= pid_hit;
		end
		if (cmd.finish && end_q) begin
			out_total_q <= total_q;
			out_sat_q   <= clamp_q;
		end
	end

	// state, running sum, clear sweep and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cur_q       <= '0;
			total_q     <= '0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.acc && hit_q) begin
				if (sum[wmpm_pkg::TOTAL_W]) begin
					total_q <= TOTAL_MAX;
					clamp_q <= 1'b1;
				end else begin
					total_q <= sum[wmpm_pkg::TOTAL_W-1:0];
				end
			end
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (end_q) begin
					cur_q       <= '0;
					total_q     <= '0;
					clamp_q     <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					cur_q <= next_q;
				end
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.strand_total = out_total_q;
	assign res.saturated    = out_sat_q;

	always_comb begin
		sts.clr_done  = 32'(clr_q) == 32'(GDEPTH - 1);
		sts.is_char   = req.req_type == wmpm_pkg::REQ_CHAR;
		sts.bad_sym   = 32'(req.symbol) >= 32'(ALPHABET);
		sts.edge_hit  = goto_rd_q[SW];
		sts.give_up   = (probe_q == '0) || (32'(steps_q) >= 32'(STATES));
		sts.list_more = i_q < span_count;
		sts.out_full  = out_valid_q && !res.ready;
		sts.is_end    = end_q;
	end
endmodule

// ----- rtl/core/wmpm_ctrl.sv -----
// ---------------------------------------------------------------------------
// wmpm_ctrl
// sequencer: clear sweep, load writes, goto/failure walk, output list scan, result hand-off
// ---------------------------------------------------------------------------
`include "weighted_multi_pattern_matcher_defines.svh"

module wmpm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wmpm_pkg::sts_t   sts,
	output wmpm_pkg::cmd_t   cmd
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_GRD   = 4'd2;
	localparam logic [3:0] S_GCHK  = 4'd3;
	localparam logic [3:0] S_SPAN  = 4'd4;
	localparam logic [3:0] S_LIST  = 4'd5;
	localparam logic [3:0] S_WT    = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q, state_d;
	logic accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (sts.is_char) begin
						cmd.char_start = 1'b1;
						state_d = sts.bad_sym ? S_SPAN : S_GRD;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_GRD: begin
				cmd.goto_rd = 1'b1;
				state_d = S_GCHK;
			end
			S_GCHK: begin
				if (sts.edge_hit || sts.give_up) begin
					cmd.take_edge = 1'b1;
					state_d = S_SPAN;
				end else begin
					cmd.goto_step = 1'b1;
					state_d = S_GRD;
				end
			end
			S_SPAN: begin
				cmd.span_rd = 1'b1;
				state_d = S_LIST;
			end
			S_LIST: begin
				if (sts.list_more) begin
					cmd.list_rd = 1'b1;
					state_d = S_WT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WT: begin
				cmd.wt_rd = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_LIST;
			end
			S_FIN: begin
				if (!(sts.is_end && sts.out_full)) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`WMPM_ASSERT_IMP(a_clear_blocks_input, state_q == S_CLEAR, !in_ready)
	`WMPM_ASSERT_IMP(a_no_result_overwrite, cmd.finish && sts.is_end, !sts.out_full)
	`WMPM_ASSERT_NXT(a_load_one_cycle, accept && !sts.is_char, state_q == S_IDLE)
endmodule

// ----- rtl/core/weighted_multi_pattern_matcher.sv -----
// steps: a load write is stored on acceptance; a text char walks the goto/failure links
//   (skipped for a symbol outside the alphabet), reads the span, then each output entry
// throughput: one transaction at a time; a strand-ending char also holds in its last step
//   while the previous strand total is still waiting on the result channel
// reset: arst_n clears the current state, sum and result flag, then a sweep over all
//   STATES*ALPHABET goto entries empties the goto table and span counts
// ---------------------------------------------------------------------------
// weighted_multi_pattern_matcher
// aho-corasick matcher summing in-range pattern weights per text strand
// ---------------------------------------------------------------------------
module weighted_multi_pattern_matcher #(
	parameter int STATES      = 4096,
	parameter int ALPHABET    = 26,
	parameter int PATTERNS    = 1024,
	parameter int OUT_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	wmpm_req_if.sink    req,
	wmpm_res_if.source  res
);
	// command and status between sequencer and datapath
	wmpm_pkg::cmd_t cmd;
	wmpm_pkg::sts_t sts;
	logic           in_ready;

	// request ready comes only from the sequencer idle state
	assign req.ready = in_ready;

	// sequencer: walks goto/failure links, then scans the state's output list
	wmpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: memories, walk registers, saturating sum, result register
	wmpm_dp #(
		.STATES      (STATES),
		.ALPHABET    (ALPHABET),
		.PATTERNS    (PATTERNS),
		.OUT_ENTRIES (OUT_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ----- bench/wmpm_check.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmpm_check
// watches both channels, predicts strand totals and compares them in order
// ---------------------------------------------------------------------------
module wmpm_check (
	input  logic        clk,
	input  logic        arst_n,
	wmpm_req_if         req,
	wmpm_res_if         res,
	output int          errors,
	output int          pending,
	output int          totals_seen,
	output int          chars_seen
);
	localparam int NSTATE = 4096;
	localparam int NSYM   = 26;
	localparam int NPAT   = 1024;
	localparam int NENT   = 4096;
	localparam logic [wmpm_pkg::TOTAL_W-1:0] TOTAL_CAP = '1;

	typedef struct packed {
		logic [wmpm_pkg::TOTAL_W-1:0] total;
		logic                         sat;
	} strand_sum_t;

	logic [12:0]                   edges_tbl [0:NSTATE*NSYM-1];
	logic [wmpm_pkg::LINK_W-1:0]   fail_tbl  [0:NSTATE-1];
	logic [wmpm_pkg::FIRST_W-1:0]  first_tbl [0:NSTATE-1];
	logic [wmpm_pkg::COUNT_W-1:0]  count_tbl [0:NSTATE-1];
	logic [wmpm_pkg::PID_W-1:0]    pid_tbl   [0:NENT-1];
	logic [wmpm_pkg::WEIGHT_W-1:0] wt_tbl    [0:NPAT-1];
	logic [wmpm_pkg::LINK_W-1:0]   cur_state;
	logic [wmpm_pkg::TOTAL_W:0]    acc_total;
	logic                          acc_sat;
	strand_sum_t                   strand_q [$];

	initial begin
		for (int i = 0; i < NSTATE*NSYM; i++) edges_tbl[i] = '0;
		for (int i = 0; i < NSTATE; i++) begin
			fail_tbl[i] = '0;
			first_tbl[i] = '0;
			count_tbl[i] = '0;
		end
		for (int i = 0; i < NENT; i++) pid_tbl[i] = '0;
		for (int i = 0; i < NPAT; i++) wt_tbl[i] = '0;
		cur_state = '0;
		acc_total = '0;
		acc_sat = 1'b0;
		errors = 0;
		totals_seen = 0;
		chars_seen = 0;
	end

	assign pending = strand_q.size();

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// walk goto edges, falling back along failure links
	function automatic logic [wmpm_pkg::LINK_W-1:0] walk(input logic [wmpm_pkg::LINK_W-1:0] s,
		input logic [wmpm_pkg::SYM_W-1:0] sym);
		int steps;
		logic [12:0] e;
		steps = 0;
		if (sym >= NSYM) return '0;
		forever begin
			e = edges_tbl[s*NSYM + sym];
			if (e[12]) return e[11:0];
			if (s == 0 || steps >= NSTATE) return '0;
			s = fail_tbl[s];
			steps++;
		end
	endfunction

	task automatic take_char();
		int idx;
		logic [wmpm_pkg::PID_W-1:0] p;
		strand_sum_t r;
		cur_state = walk(cur_state, req.symbol);
		chars_seen++;
		for (int i = 0; i < count_tbl[cur_state]; i++) begin
			idx = first_tbl[cur_state] + i;
			if (idx >= NENT) continue;
			p = pid_tbl[idx];
			if (p >= req.range_first && p <= req.range_last) begin
				acc_total = acc_total + wt_tbl[p];
				if (acc_total > TOTAL_CAP) begin
					acc_total = TOTAL_CAP;
					acc_sat = 1'b1;
				end
			end
		end
		if (req.strand_end) begin
			r.total = acc_total[wmpm_pkg::TOTAL_W-1:0];
			r.sat = acc_sat;
			strand_q = {strand_q, r};
			cur_state = '0;
			acc_total = '0;
			acc_sat = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			case (req.req_type)
				wmpm_pkg::REQ_GOTO: if (req.symbol < NSYM)
					edges_tbl[req.slot*NSYM + req.symbol] = req.has_edge ? {1'b1, req.link} : '0;
				wmpm_pkg::REQ_INFO: begin
					fail_tbl[req.slot] = req.link;
					first_tbl[req.slot] = req.out_first;
					count_tbl[req.slot] = req.out_count;
				end
				wmpm_pkg::REQ_OUTPUT: pid_tbl[req.slot] = req.pattern_id;
				wmpm_pkg::REQ_WEIGHT: if (req.slot < NPAT) wt_tbl[req.slot] = req.weight;
				wmpm_pkg::REQ_CHAR: take_char();
				default: ;
			endcase
		end
		if (arst_n && res.valid && res.ready) begin
			totals_seen++;
			if (strand_q.size() == 0)
				report("strand total with none expected");
			else begin
				strand_sum_t want;
				want = strand_q.pop_front();
				if (res.strand_total !== want.total)
					report($sformatf("strand_total got %0h want %0h",
						res.strand_total, want.total));
				if (res.saturated !== want.sat)
					report($sformatf("saturated got %0b want %0b", res.saturated, want.sat));
			end
		end
	end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// loads a small automaton, runs a saturating strand, directed corners and
// random strands with rewrites; a side checker predicts every strand total
// ---------------------------------------------------------------------------
module testbench;
	localparam int CYCLE_LIMIT = 40000000;
	localparam int RAND_ITEMS  = 760;

	logic clk;
	logic arst_n;
	int   errors, pending, totals_seen, chars_seen;
	int   cycles;
	int   burst_left;

	wmpm_req_if req_ch ();
	wmpm_res_if res_ch ();

	weighted_multi_pattern_matcher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	wmpm_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.res         (res_ch),
		.errors      (errors),
		.pending     (pending),
		.totals_seen (totals_seen),
		.chars_seen  (chars_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, sized for the goto clear sweep plus chars that each walk the
	// longest failure chain
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver stall pattern: quiet stretches, then heavy random back-pressure
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ((cycles / 3000) % 3 == 0) res_ch.ready = 1'b1;
			else res_ch.ready = ($urandom_range(0, 2) != 0);
		end
	end

	// a pool of 16 states keeps every failure link written before it is read
	function automatic logic [wmpm_pkg::LINK_W-1:0] pool_state(input int k);
		return (k < 15) ? wmpm_pkg::LINK_W'(k) : '1;
	endfunction

	// patterns that may appear in list entries; all get a weight up front
	function automatic logic [wmpm_pkg::PID_W-1:0] pool_pid(input int k);
		return (k < 32) ? wmpm_pkg::PID_W'(k) :
			(k == 32) ? wmpm_pkg::PID_W'(512) : wmpm_pkg::PID_W'(1023);
	endfunction

	task automatic idle_fields();
		req_ch.req_type    = wmpm_pkg::REQ_W'($urandom);
		req_ch.slot        = wmpm_pkg::SLOT_W'($urandom);
		req_ch.symbol      = wmpm_pkg::SYM_W'($urandom);
		req_ch.link        = wmpm_pkg::LINK_W'($urandom);
		req_ch.has_edge    = 1'($urandom);
		req_ch.out_first   = wmpm_pkg::FIRST_W'($urandom);
		req_ch.out_count   = wmpm_pkg::COUNT_W'($urandom);
		req_ch.pattern_id  = wmpm_pkg::PID_W'($urandom);
		req_ch.weight      = wmpm_pkg::WEIGHT_W'($urandom);
		req_ch.range_first = wmpm_pkg::PID_W'($urandom);
		req_ch.range_last  = wmpm_pkg::PID_W'($urandom);
		req_ch.strand_end  = 1'($urandom);
	endtask

	// fields are already set by the caller; this handles gaps and the handshake
	task automatic push();
		if (burst_left == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_goto(input int st, input int sym, input int dst, input bit on);
		idle_fields();
		req_ch.req_type = wmpm_pkg::REQ_GOTO;
		req_ch.slot = wmpm_pkg::SLOT_W'(st);
		req_ch.symbol = wmpm_pkg::SYM_W'(sym);
		req_ch.link = wmpm_pkg::LINK_W'(dst);
		req_ch.has_edge = on;
		push();
	endtask

	task automatic send_info(input int st, input int fl, input int first, input int cnt);
		idle_fields();
		req_ch.req_type = wmpm_pkg::REQ_INFO;
		req_ch.slot = wmpm_pkg::SLOT_W'(st);
		req_ch.link = wmpm_pkg::LINK_W'(fl);
		req_ch.out_first = wmpm_pkg::FIRST_W'(first);
		req_ch.out_count = wmpm_pkg::COUNT_W'(cnt);
		push();
	endtask

	task automatic send_entry(input int e, input int p);
		idle_fields();
		req_ch.req_type = wmpm_pkg::REQ_OUTPUT;
		req_ch.slot = wmpm_pkg::SLOT_W'(e);
		req_ch.pattern_id = wmpm_pkg::PID_W'(p);
		push();
	endtask

	task automatic send_weight(input int p, input int w);
		idle_fields();
		req_ch.req_type = wmpm_pkg::REQ_WEIGHT;
		req_ch.slot = wmpm_pkg::SLOT_W'(p);
		req_ch.weight = wmpm_pkg::WEIGHT_W'(w);
		push();
	endtask

	task automatic send_char(input int sym, input int lo, input int hi, input bit last);
		idle_fields();
		req_ch.req_type = wmpm_pkg::REQ_CHAR;
		req_ch.symbol = wmpm_pkg::SYM_W'(sym);
		req_ch.range_first = wmpm_pkg::PID_W'(lo);
		req_ch.range_last = wmpm_pkg::PID_W'(hi);
		req_ch.strand_end = last;
		push();
	endtask

	// spans start in written list entries: the low block, or the top block that may run past the end
	task automatic random_info(input int st);
		if ($urandom_range(0, 3) == 0)
			send_info(st, pool_state($urandom_range(0, 15)), $urandom_range(4088, 4095),
				$urandom_range(0, 8));
		else
			send_info(st, pool_state($urandom_range(0, 15)), $urandom_range(0, 248),
				$urandom_range(0, 8));
	endtask

	task automatic random_char();
		int lo, hi;
		case ($urandom_range(0, 3))
			0: begin lo = $urandom_range(0, 1023); hi = $urandom_range(0, 1023); end
			1: begin lo = $urandom_range(0, 20); hi = $urandom_range(10, 1023); end
			default: begin lo = 0; hi = 1023; end
		endcase
		send_char(($urandom_range(0, 30) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25),
			lo, hi, $urandom_range(0, 5) == 0);
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		burst_left = 0;
		req_ch.valid = 1'b0;
		idle_fields();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// weights for every pattern a list entry may name; 1023 gets the maximum
		for (int k = 0; k < 34; k++)
			send_weight(pool_pid(k), (k == 33) ? 24'hFFFFFF : (k == 0) ? 0 : $urandom);

		// saturation setup: entries 0..255 all name the heaviest pattern
		for (int e = 0; e < 256; e++) send_entry(e, 1023);
		for (int e = 4088; e < 4096; e++) send_entry(e, pool_pid($urandom_range(0, 33)));
		for (int k = 0; k < 16; k++) begin
			if (k == 1) send_info(1, 0, 0, 256);
			else random_info(pool_state(k));
		end
		send_goto(0, 0, 1, 1'b1);
		send_goto(1, 0, 1, 1'b1);
		// long strand pinned in state 1 overflows the 40-bit sum
		for (int c = 0; c < 257; c++) send_char(0, 0, 1023, c == 256);

		// directed corners
		send_char(31, 0, 1023, 1'b1);              // bad text symbol ends the strand
		send_char(0, 900, 5, 1'b0);                // empty pattern range
		send_char(0, 1023, 1023, 1'b1);            // range at the top index only
		send_char(25, 0, 1023, 1'b1);              // root with no edge stays at root
		for (int t = 5; t < 8; t++) begin          // unknown request codes
			idle_fields();
			req_ch.req_type = wmpm_pkg::REQ_W'(t);
			push();
		end
		send_goto(2, 31, 3, 1'b1);                 // symbol beyond the alphabet
		send_weight(4095, 24'h123456);             // pattern slot beyond the store
		send_info(2000, 4095, 4095, 1024);         // unreachable state, all-ones link and first entry
		send_goto(3000, 25, 4095, 1'b1);           // unreachable state edge
		send_goto(0, 25, 4095, 1'b1);              // edge into the top state
		send_char(25, 0, 1023, 1'b0);
		send_char(0, 0, 1023, 1'b1);

		// replace the saturating content with a mixed pattern list
		for (int e = 0; e < 256; e++) send_entry(e, pool_pid($urandom_range(0, 33)));
		random_info(1);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				// drain everything before going on
				req_ch.valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) random_char();
			else if (pick < 85)
				send_goto(pool_state($urandom_range(0, 15)), $urandom_range(0, 25),
					pool_state($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
			else if (pick < 90) random_info(pool_state($urandom_range(1, 15)));
			else if (pick < 95)
				send_entry(($urandom_range(0, 3) == 0) ? $urandom_range(4088, 4095)
					: $urandom_range(0, 255), pool_pid($urandom_range(0, 33)));
			else if (pick < 97)
				send_weight(pool_pid($urandom_range(0, 33)),
					($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom);
			else begin
				idle_fields();
				req_ch.req_type = wmpm_pkg::REQ_W'($urandom_range(5, 7));
				push();
			end
		end
		send_char(0, 0, 1023, 1'b1);               // close any open strand
		req_ch.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("covered %0d text chars and %0d strand totals, incl. a saturated strand",
			chars_seen, totals_seen);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL");
		end
		$finish;
	end
endmodule
